>>> src/mcts_pkg.sv
// Shared types and constants for the min/max column trace segment block.
// No dependencies; every other file refers to it by scoped names.
package mcts_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 128;
    localparam int COL_W          = $clog2(SCREEN_COLUMNS + 1);

    // Field widths
    localparam int ADC_W   = 12;
    localparam int POS_W   = 16;
    localparam int COORD_W = 7;
    localparam int SCALE_W = 16;

    // Sample-to-row mapping constants
    localparam int PROD_W   = 24;
    localparam int MV_FULL  = 3300;
    localparam int MV_MID   = 1650;
    localparam int ROW_MID  = 64;
    localparam int ROW_MAX  = 127;
    localparam int QUO_W    = 15;

    // Configuration register map
    localparam int        PADDR_W        = 3;
    localparam int        PDATA_W        = 32;
    localparam logic      REG_MV_PER_DIV = 1'b0;
    localparam logic [SCALE_W-1:0] MV_PER_DIV_RESET = 16'd1000;

    // One column bucket
    typedef struct packed {
        logic [ADC_W-1:0] first_sample;
        logic [ADC_W-1:0] final_sample;
        logic [ADC_W-1:0] min_sample;
        logic [ADC_W-1:0] max_sample;
        logic [POS_W-1:0] sample_count;
        logic [POS_W-1:0] min_position;
        logic [POS_W-1:0] max_position;
        logic             last_bucket;
    } bucket_t;

    // One drawn segment
    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               last_segment;
    } segment_t;

    // Status from the row conversion unit
    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] row;
    } row_stat_t;

endpackage

>>> src/minmax_column_trace_segments_core.sv
// Top level of the min/max column trace segment block: bucket sequencer,
// segment output register, row unit and configuration register.
// Depends on mcts_pkg, mcts_row_unit and mcts_cfg_regs.
//
//   Channel   Signals                              Beat moves
//   bucket    bucket_valid, bucket_ready, bucket   one column bucket in
//   segment   segment_valid, segment_ready, segment one line segment out
//   config    psel, penable, pwrite, paddr, ...    scale register write/read
//
// An on-screen bucket has its four samples converted one after another
// through the single row unit and its 15-step serial divide, then emits one
// segment per cycle, 1 to 4, while segment_ready does not stall the output.
// An off-screen bucket is taken with no conversion and no segment. Reset
// clears the column state and sets the scale to 1000. A stalled segment beat
// holds; the next bucket is still taken while the final segment waits.
module minmax_column_trace_segments_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         bucket_valid,
    output logic                         bucket_ready,
    input  mcts_pkg::bucket_t            bucket,
    output logic                         segment_valid,
    input  logic                         segment_ready,
    output mcts_pkg::segment_t           segment,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcts_pkg::PADDR_W-1:0] paddr,
    input  logic [mcts_pkg::PDATA_W-1:0] pwdata,
    output logic [mcts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } state_t;

    localparam int CW = mcts_pkg::COORD_W;

    state_t                           state_reg, state_next;
    mcts_pkg::bucket_t                bkt_reg, bkt_next;
    logic [mcts_pkg::COL_W-1:0]       col_reg, col_next;
    logic [CW-1:0]                    prev_row_reg, prev_row_next;
    logic                             has_prev_reg, has_prev_next;
    logic [1:0]                       conv_k_reg, conv_k_next;
    logic                             start_reg, start_next;
    logic [CW-1:0]                    yf_reg, yf_next;
    logic [CW-1:0]                    yl_reg, yl_next;
    logic [CW-1:0]                    ymin_reg, ymin_next;
    logic [CW-1:0]                    ymax_reg, ymax_next;
    logic [1:0]                       seg_idx_reg, seg_idx_next;
    logic                             seg_valid_reg, seg_valid_next;
    mcts_pkg::segment_t               seg_reg, seg_next;

    logic [mcts_pkg::SCALE_W-1:0]     divisor;
    logic [mcts_pkg::ADC_W-1:0]       conv_adc;
    mcts_pkg::row_stat_t              row_stat;

    logic                             accept;
    logic                             on_screen;
    logic                             has_conn;
    logic                             three_seg;
    logic [2:0]                       seg_total;
    logic [1:0]                       vert_j;
    logic [CW-1:0]                    pt_a, pt_b;
    logic [CW-1:0]                    x_cur;
    logic                             load_seg;
    mcts_pkg::segment_t               seg_build;

    mcts_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .divisor (divisor)
    );

    mcts_row_unit u_row
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .adc     (conv_adc),
        .divisor (divisor),
        .stat    (row_stat)
    );

    // Pick the sample under conversion
    always_comb
    begin
        case (conv_k_reg)
            2'd0:    conv_adc = bkt_reg.first_sample;
            2'd1:    conv_adc = bkt_reg.final_sample;
            2'd2:    conv_adc = bkt_reg.min_sample;
            default: conv_adc = bkt_reg.max_sample;
        endcase
    end

    assign bucket_ready  = (state_reg == S_IDLE);
    assign accept        = bucket_valid && bucket_ready;
    assign on_screen     = (col_reg < mcts_pkg::COL_W'(mcts_pkg::SCREEN_COLUMNS));
    assign segment_valid = seg_valid_reg;
    assign segment       = seg_reg;

    // Segment list for the current column
    assign x_cur     = col_reg[CW-1:0];
    assign has_conn  = has_prev_reg && (col_reg != '0);
    assign three_seg = (bkt_reg.sample_count > 16'd1)
                    && (bkt_reg.min_position != bkt_reg.max_position);
    assign seg_total = 3'(has_conn) + (three_seg ? 3'd3 : 3'd1);
    assign vert_j    = has_conn ? (seg_idx_reg - 2'd1) : seg_idx_reg;
    assign pt_a      = (bkt_reg.min_position < bkt_reg.max_position) ? ymin_reg : ymax_reg;
    assign pt_b      = (bkt_reg.min_position < bkt_reg.max_position) ? ymax_reg : ymin_reg;

    always_comb
    begin
        seg_build.x_start = x_cur;
        seg_build.x_end   = x_cur;
        seg_build.y_start = yf_reg;
        seg_build.y_end   = yl_reg;
        if (has_conn && (seg_idx_reg == 2'd0))
        begin
            seg_build.x_start = x_cur - 7'd1;
            seg_build.y_start = prev_row_reg;
            seg_build.y_end   = yf_reg;
        end
        else if (three_seg)
        begin
            case (vert_j)
                2'd0:
                begin
                    seg_build.y_start = yf_reg;
                    seg_build.y_end   = pt_a;
                end
                2'd1:
                begin
                    seg_build.y_start = pt_a;
                    seg_build.y_end   = pt_b;
                end
                default:
                begin
                    seg_build.y_start = pt_b;
                    seg_build.y_end   = yl_reg;
                end
            endcase
        end
        seg_build.last_segment = ({1'b0, seg_idx_reg} == (seg_total - 3'd1));
    end

    assign load_seg = (state_reg == S_EMIT) && (!seg_valid_reg || segment_ready);

    // Sequencer: accept a bucket; on screen, convert four samples, emit segments
    always_comb
    begin
        state_next     = state_reg;
        bkt_next       = bkt_reg;
        col_next       = col_reg;
        prev_row_next  = prev_row_reg;
        has_prev_next  = has_prev_reg;
        conv_k_next    = conv_k_reg;
        start_next     = 1'b0;
        yf_next        = yf_reg;
        yl_next        = yl_reg;
        ymin_next      = ymin_reg;
        ymax_next      = ymax_reg;
        seg_idx_next   = seg_idx_reg;
        seg_valid_next = seg_valid_reg;
        seg_next       = seg_reg;

        // Drop the output beat once taken
        if (seg_valid_reg && segment_ready)
        begin
            seg_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bkt_next = bucket;
                    if (on_screen)
                    begin
                        conv_k_next = 2'd0;
                        start_next  = 1'b1;
                        state_next  = S_CONV;
                    end
                    else if (bucket.last_bucket)
                    begin
                        col_next      = '0;
                        prev_row_next = '0;
                        has_prev_next = 1'b0;
                    end
                end
            end
            S_CONV:
            begin
                if (row_stat.done)
                begin
                    case (conv_k_reg)
                        2'd0:    yf_next   = row_stat.row;
                        2'd1:    yl_next   = row_stat.row;
                        2'd2:    ymin_next = row_stat.row;
                        default: ymax_next = row_stat.row;
                    endcase
                    if (conv_k_reg == 2'd3)
                    begin
                        seg_idx_next = 2'd0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        conv_k_next = conv_k_reg + 2'd1;
                        start_next  = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (load_seg)
                begin
                    seg_next       = seg_build;
                    seg_valid_next = 1'b1;
                    seg_idx_next   = seg_idx_reg + 2'd1;
                    if (seg_build.last_segment)
                    begin
                        state_next = S_IDLE;
                        if (bkt_reg.last_bucket)
                        begin
                            col_next      = '0;
                            prev_row_next = '0;
                            has_prev_next = 1'b0;
                        end
                        else
                        begin
                            col_next      = col_reg + mcts_pkg::COL_W'(1);
                            prev_row_next = yl_reg;
                            has_prev_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, column history and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bkt_reg       <= '0;
            col_reg       <= '0;
            prev_row_reg  <= '0;
            has_prev_reg  <= 1'b0;
            conv_k_reg    <= '0;
            start_reg     <= 1'b0;
            yf_reg        <= '0;
            yl_reg        <= '0;
            ymin_reg      <= '0;
            ymax_reg      <= '0;
            seg_idx_reg   <= '0;
            seg_valid_reg <= 1'b0;
            seg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bkt_reg       <= bkt_next;
            col_reg       <= col_next;
            prev_row_reg  <= prev_row_next;
            has_prev_reg  <= has_prev_next;
            conv_k_reg    <= conv_k_next;
            start_reg     <= start_next;
            yf_reg        <= yf_next;
            yl_reg        <= yl_next;
            ymin_reg      <= ymin_next;
            ymax_reg      <= ymax_next;
            seg_idx_reg   <= seg_idx_next;
            seg_valid_reg <= seg_valid_next;
            seg_reg       <= seg_next;
        end
    end

endmodule

>>> src/mcts_cfg_regs.sv
// APB-style configuration register holding the vertical scale.
// Depends on mcts_pkg.
module mcts_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mcts_pkg::PADDR_W-1:0]         paddr,
    input  logic [mcts_pkg::PDATA_W-1:0]         pwdata,
    output logic [mcts_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    output logic [mcts_pkg::SCALE_W-1:0]         divisor
);

    logic [mcts_pkg::SCALE_W-1:0] mv_per_div_reg;
    logic                         reg_sel;

    assign reg_sel = (paddr[2] == mcts_pkg::REG_MV_PER_DIV);
    assign pready  = 1'b1;

    // Capture the scale on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_per_div_reg <= mcts_pkg::MV_PER_DIV_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            mv_per_div_reg <= pwdata[mcts_pkg::SCALE_W-1:0];
        end
    end

    // Return the stored value on reads
    assign prdata = reg_sel ? {{(mcts_pkg::PDATA_W - mcts_pkg::SCALE_W){1'b0}}, mv_per_div_reg}
                            : '0;

    // Treat a zero scale as one
    assign divisor = (mv_per_div_reg == '0) ? {{(mcts_pkg::SCALE_W-1){1'b0}}, 1'b1}
                                            : mv_per_div_reg;

endmodule

>>> src/mcts_row_unit.sv
// Shared sample-to-row converter: constant scale to millivolts, then a
// bit-serial restoring divide by the configured scale. Depends on mcts_pkg.
module mcts_row_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mcts_pkg::ADC_W-1:0]        adc,
    input  logic [mcts_pkg::SCALE_W-1:0]      divisor,
    output mcts_pkg::row_stat_t               stat
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_PREP,
        R_DIV,
        R_FIN
    } rstate_t;

    rstate_t                          state_reg, state_next;
    logic [mcts_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [mcts_pkg::QUO_W-1:0]       num_reg, num_next;
    logic [mcts_pkg::SCALE_W-1:0]     rem_reg, rem_next;
    logic [3:0]                       cnt_reg, cnt_next;
    logic                             neg_reg, neg_next;

    logic [mcts_pkg::PROD_W-1:0]      recip_sum;
    logic [mcts_pkg::ADC_W-1:0]       mv;
    logic [10:0]                      mag;
    logic [mcts_pkg::SCALE_W:0]       trial;
    logic                             trial_ge;
    logic [mcts_pkg::SCALE_W-1:0]     row_sum;
    logic [mcts_pkg::COORD_W-1:0]     row;

    // Divide by 4095 through its reciprocal: exact for products below 4095 * 4096
    assign recip_sum = prod_reg + {12'd0, prod_reg[mcts_pkg::PROD_W-1:12]}
                     + {{(mcts_pkg::PROD_W-1){1'b0}}, 1'b1};
    assign mv        = recip_sum[mcts_pkg::PROD_W-1:12];
    assign mag       = (mv < 12'(mcts_pkg::MV_MID)) ? 11'(12'(mcts_pkg::MV_MID) - mv)
                                                    : 11'(mv - 12'(mcts_pkg::MV_MID));

    // One quotient bit per cycle
    assign trial    = {rem_reg, num_reg[mcts_pkg::QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor});

    // Offset from mid-screen and clamp
    assign row_sum = 16'(mcts_pkg::ROW_MID) + {1'b0, num_reg};
    always_comb
    begin
        if (neg_reg)
        begin
            row = (row_sum > 16'(mcts_pkg::ROW_MAX)) ? 7'(mcts_pkg::ROW_MAX) : row_sum[6:0];
        end
        else
        begin
            row = (num_reg > 15'(mcts_pkg::ROW_MID)) ? 7'd0
                                                     : 7'(15'(mcts_pkg::ROW_MID) - num_reg);
        end
    end

    assign stat.done = (state_reg == R_FIN);
    assign stat.row  = row;

    // Sequence: multiply, prepare magnitude, fifteen divide steps, finish
    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    prod_next  = 24'(adc) * 24'(mcts_pkg::MV_FULL);
                    state_next = R_PREP;
                end
            end
            R_PREP:
            begin
                neg_next   = (mv < 12'(mcts_pkg::MV_MID));
                num_next   = {mag, 4'd0};
                rem_next   = '0;
                cnt_next   = 4'(mcts_pkg::QUO_W - 1);
                state_next = R_DIV;
            end
            R_DIV:
            begin
                rem_next = trial_ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
                num_next = {num_reg[mcts_pkg::QUO_W-2:0], trial_ge};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = R_FIN;
                end
            end
            R_FIN:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            prod_reg  <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
            num_reg   <= num_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
        end
    end

endmodule
